FILE: hw/rtl/mpn_pkg.sv
// Shared types and constants of the mount path normalizer.
// Holds the transaction payload structs, the job record that runs from the
// front to the back, and the character and capacity constants.
`timescale 1ns / 1ps

package mpn_pkg;

  // Width of the capacity register and of the kept length counter.
  localparam int unsigned CapW = 13;

  // Capacity limits and reset value.
  localparam logic [CapW-1:0] MaxCapacity = 13'd4096;
  localparam logic [CapW-1:0] MinCapacity = 13'd3;
  localparam logic [CapW-1:0] CapReset    = 13'd256;

  // Characters the front looks for.
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpZ    = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'h20;
  localparam logic [7:0] CharNul    = 8'h00;

  // Number of held characters after a path reset (the leading slash).
  localparam logic [1:0] HeldReset = 2'd1;

  // Job queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       is_end;
  } mpn_in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       is_verdict;
    logic       accepted;
  } mpn_out_t;

  // Work for one input item. The held characters are always a slash
  // followed by dots, so only their count travels.
  typedef struct packed {
    logic [1:0] flush_cnt;
    logic       emit_ch;
    logic [7:0] ch;
    logic       root;
    logic       verdict;
    logic       ok;
  } mpn_job_t;

endpackage

FILE: hw/rtl/mpn_front.sv
// Front of the mount path normalizer: accepts input transactions, tracks
// the path state and the capacity register, and issues at most one job per item.
// Depends on mpn_pkg.
`timescale 1ns / 1ps

module mpn_front
  import mpn_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mpn_in_t         in_data_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output mpn_job_t        job_o
);

  logic [CapW-1:0] capacity_q;
  logic            in_lead_q, in_lead_d;
  logic [CapW-1:0] kept_q, kept_d;
  logic [1:0]      held_q, held_d;
  logic            rej_q, rej_d;
  logic            saw_q, saw_d;

  logic            accept;
  logic [CapW-1:0] eff_cap;
  logic            cap_low;
  logic            take;
  logic [7:0]      lc;
  logic [CapW:0]   kept_inc;
  mpn_job_t        job;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Capacity values above the maximum act as the maximum.
  assign eff_cap = (capacity_q > MaxCapacity) ? MaxCapacity : capacity_q;
  assign cap_low = eff_cap < MinCapacity;
  assign take    = in_data_i.has_char && (in_data_i.ch != CharNul);
  assign kept_inc = {1'b0, kept_q} + {{CapW{1'b0}}, 1'b1};

  // ASCII capitals fold to lower case.
  always_comb begin
    lc = in_data_i.ch;
    if (in_data_i.ch >= CharUpA && in_data_i.ch <= CharUpZ) begin
      lc = in_data_i.ch + CaseOffset;
    end
  end

  // Character handling, then the end of path verdict.
  always_comb begin
    in_lead_d = in_lead_q;
    kept_d    = kept_q;
    held_d    = held_q;
    rej_d     = rej_q;
    saw_d     = saw_q;
    job       = '0;

    if (take) begin
      saw_d = 1'b1;
      if (cap_low) begin
        rej_d = 1'b1;
      end
      if (!rej_d) begin
        if (!(in_lead_q && in_data_i.ch == CharSlash)) begin
          in_lead_d = 1'b0;
          if (!(in_data_i.ch == CharSlash && held_q == 2'd1)) begin
            if (kept_inc >= {1'b0, eff_cap}) begin
              rej_d = 1'b1;
            end else begin
              kept_d = kept_inc[CapW-1:0];
              if (lc == CharSlash) begin
                // A slash after held dots closes a dot component and rejects the path.
                if (held_q >= 2'd2) begin
                  rej_d = 1'b1;
                end else begin
                  held_d = 2'd1;
                end
              end else if (lc == CharDot && (held_q == 2'd1 || held_q == 2'd2)) begin
                held_d = held_q + 2'd1;
              end else begin
                job.flush_cnt = held_q;
                job.emit_ch   = 1'b1;
                job.ch        = lc;
                held_d        = 2'd0;
              end
            end
          end
        end
      end
    end

    if (in_data_i.is_end) begin
      job.verdict = 1'b1;
      job.ok      = !rej_d && saw_d && !cap_low && (held_d < 2'd2);
      // A lone held slash leaves only when the path is the root.
      job.root    = job.ok && (held_d == 2'd1) && (kept_d == {{(CapW-1){1'b0}}, 1'b1});
      in_lead_d   = 1'b1;
      kept_d      = {{(CapW-1){1'b0}}, 1'b1};
      held_d      = HeldReset;
      rej_d       = 1'b0;
      saw_d       = 1'b0;
    end
  end

  assign job_o       = job;
  assign job_valid_o = accept && (job.emit_ch || job.verdict);

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Path state advances on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_lead_q <= 1'b1;
      kept_q    <= {{(CapW-1){1'b0}}, 1'b1};
      held_q    <= HeldReset;
      rej_q     <= 1'b0;
      saw_q     <= 1'b0;
    end else if (accept) begin
      in_lead_q <= in_lead_d;
      kept_q    <= kept_d;
      held_q    <= held_d;
      rej_q     <= rej_d;
      saw_q     <= saw_d;
    end
  end

endmodule

FILE: hw/rtl/mpn_queue.sv
// Job queue of the mount path normalizer, a small register FIFO that lets
// the front and the back stall on their own.
// Depends on mpn_pkg.
`timescale 1ns / 1ps

module mpn_queue
  import mpn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  mpn_job_t push_data_i,
  output logic     not_full_o,
  input  logic     pop_i,
  output logic     not_empty_o,
  output mpn_job_t pop_data_o
);

  mpn_job_t             entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push;
  logic                 do_pop;

  assign not_full_o  = count_q != QueueCntW'(QueueDepth);
  assign not_empty_o = count_q != '0;
  assign pop_data_o  = entries_q[rd_ptr_q];
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;

  // Storage needs no reset; only the pointers and the count are control.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/mpn_back.sv
// Back of the mount path normalizer: expands each job into its result
// transactions into the output register, one a cycle while it is not stalled.
// Depends on mpn_pkg.
`timescale 1ns / 1ps

module mpn_back
  import mpn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  mpn_job_t job_i,
  output logic     job_pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mpn_out_t out_data_o
);

  mpn_job_t   cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [1:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  mpn_out_t   out_q, out_d;

  logic       step;
  logic       last;
  logic       load;
  mpn_out_t   res;
  mpn_job_t   rest;
  logic [1:0] pos_next;

  assign step = cur_valid_q && (!out_valid_q || out_ready_i);

  // Pick the next result of the current job: held characters, the
  // character, the root slash, then the verdict.
  always_comb begin
    res      = '0;
    rest     = cur_q;
    pos_next = pos_q;
    if (pos_q < cur_q.flush_cnt) begin
      res.out_char   = (pos_q == 2'd0) ? CharSlash : CharDot;
      res.char_valid = 1'b1;
      pos_next       = pos_q + 2'd1;
    end else if (cur_q.emit_ch) begin
      res.out_char   = cur_q.ch;
      res.char_valid = 1'b1;
      rest.emit_ch   = 1'b0;
    end else if (cur_q.root) begin
      res.out_char   = CharSlash;
      res.char_valid = 1'b1;
      rest.root      = 1'b0;
    end else begin
      res.is_verdict = 1'b1;
      res.accepted   = cur_q.ok;
      rest.verdict   = 1'b0;
    end
    last = (pos_next >= cur_q.flush_cnt) && !rest.emit_ch && !rest.root && !rest.verdict;
  end

  // Current job register and its refill from the queue.
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    pos_d       = pos_q;
    load        = !cur_valid_q || (step && last);
    if (step) begin
      cur_d = rest;
      pos_d = pos_next;
    end
    if (load) begin
      cur_valid_d = job_valid_i;
      cur_d       = job_i;
      pos_d       = 2'd0;
    end
  end

  assign job_pop_o = load && job_valid_i;

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (step) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/mount_path_normalizer_unit.sv
// Top level of the mount path normalizer.
// Instantiates mpn_front, mpn_queue and mpn_back; depends on mpn_pkg.
//
// The block takes one path character per input transaction, ending with an
// item that has is_end set, and returns the canonical mount path followed by
// one verdict transaction; on a reject the consumer drops the characters of
// that path. An input transaction is taken in every cycle while the four
// entry job queue has room, and each one yields from zero to five results.
// While out_ready_i is high the output port delivers one result per cycle,
// so the sustained rate is one item per cycle for items that yield at most
// one result, and bursts of held characters drain at one per cycle. The first
// result of an item passes through the job queue, the current job register of
// the back and the output register before it is valid at the output.
// The capacity register is written with cfg_we_i and applies to later items.
`timescale 1ns / 1ps

module mount_path_normalizer_unit
  import mpn_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mpn_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mpn_out_t        out_data_o
);

  logic     push;
  mpn_job_t push_job;
  logic     not_full;
  logic     pop;
  logic     not_empty;
  mpn_job_t head_job;

  // Front classifies each transaction into a job.
  mpn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (push),
    .job_ready_i (not_full),
    .job_o       (push_job)
  );

  // Queue decouples the two sides.
  mpn_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .not_full_o  (not_full),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .pop_data_o  (head_job)
  );

  // Back serializes jobs into result transactions.
  mpn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (not_empty),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
